// ===== rtl/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg
// shared widths, register indexes and function codes of the line rasterizer
// ----------------------------------------------------------------------------
package mlr_pkg;

    // default geometry
    localparam int COORD_BITS_DEF   = 12;
    localparam int ADDRESS_BITS_DEF = 32;

    // fixed field widths
    localparam int PITCH_W   = 16;
    localparam int BASE_W    = 32;
    localparam int COLOR_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(640);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_PITCH   = 1'b0,
        REG_SURFACE_BASE = 1'b1
    } t_cfg_reg;

    // input function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

endpackage

// ===== rtl/midpoint_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// midpoint line walker with framebuffer byte address generation
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  in       | i_in_valid / o_in_stall  | i_func, i_start_x/y, i_end_x/y, color
//  out      | o_out_valid / i_out_stall| o_pixel_x/y, color, address, last
//  cfg      | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  one item per clock while o_in_stall is low; a pixel passes the line state
//  stage, pitch multiply stage and address add stage (the output register)
//  the line state loop (one decision add and one minor step) is combinational
//  sync active-low reset clears line state, valids, base; sets pitch to 640
//  a stalled output holds the pipe only as far back as the first empty stage
//  a step transfer with no active line makes no pixel
//
module midpoint_line_rasterizer #(
    parameter int COORD_BITS   = mlr_pkg::COORD_BITS_DEF,
    parameter int ADDRESS_BITS = mlr_pkg::ADDRESS_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_func,
    input  logic [COORD_BITS-1:0]        i_start_x,
    input  logic [COORD_BITS-1:0]        i_start_y,
    input  logic [COORD_BITS-1:0]        i_end_x,
    input  logic [COORD_BITS-1:0]        i_end_y,
    input  logic [mlr_pkg::COLOR_W-1:0]  i_draw_color,
    // pixel output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [COORD_BITS-1:0]        o_pixel_x,
    output logic [COORD_BITS-1:0]        o_pixel_y,
    output logic [mlr_pkg::COLOR_W-1:0]  o_pixel_color,
    output logic [ADDRESS_BITS-1:0]      o_pixel_address,
    output logic                         o_last_pixel,
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mlr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mlr_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import mlr_pkg::*;

    // decision term spans +-2*(2^COORD_BITS - 1), plus sign
    localparam int DEC_W  = COORD_BITS + 3;
    localparam int PROD_W = COORD_BITS + PITCH_W;
    localparam int EXT_W  = (ADDRESS_BITS > BASE_W) ? ADDRESS_BITS : BASE_W;

    // configuration registers
    logic [PITCH_W-1:0] r_pitch;
    logic [BASE_W-1:0]  r_base;

    // line state
    logic [COORD_BITS-1:0]   r_cur_major, n_cur_major;
    logic [COORD_BITS-1:0]   r_cur_minor, n_cur_minor;
    logic [COORD_BITS-1:0]   r_major_end, n_major_end;
    logic signed [DEC_W-1:0] r_decision, n_decision;
    logic signed [DEC_W-1:0] r_straight, n_straight;
    logic signed [DEC_W-1:0] r_diagonal, n_diagonal;
    logic                    r_minor_down, n_minor_down;
    logic                    r_y_major, n_y_major;
    logic                    r_busy, n_busy;
    logic [COLOR_W-1:0]      r_color, n_color;

    // stage a: pixel coordinates
    logic                  r_a_valid;
    logic [COORD_BITS-1:0] r_a_px, r_a_py;
    logic [COLOR_W-1:0]    r_a_color;
    logic                  r_a_last;
    // stage b: row offset product
    logic                  r_b_valid;
    logic [COORD_BITS-1:0] r_b_px, r_b_py;
    logic [COLOR_W-1:0]    r_b_color;
    logic                  r_b_last;
    logic [PROD_W-1:0]     r_b_prod;
    // stage c: output register
    logic                    r_c_valid;
    logic [COORD_BITS-1:0]   r_c_px, r_c_py;
    logic [COLOR_W-1:0]      r_c_color;
    logic                    r_c_last;
    logic [ADDRESS_BITS-1:0] r_c_addr;

    logic in_xfer, emit;
    logic a_ready, b_ready, c_ready;

    // start decode
    logic [COORD_BITS-1:0] dx, dy, dmaj, dmin;
    logic [COORD_BITS-1:0] ma0, mi0, ma1, mi1;
    logic                  ymaj_s, swap;
    logic signed [DEC_W-1:0] two_dmin, two_dmaj, one_dmaj;
    logic [COORD_BITS-1:0] step_major;
    logic [EXT_W-1:0]      addr_sum;

    // ready chain, each stage frees when the next one takes its data
    assign c_ready    = !r_c_valid || !i_out_stall;
    assign b_ready    = !r_b_valid || c_ready;
    assign a_ready    = !r_a_valid || b_ready;
    assign o_in_stall = !a_ready;
    assign in_xfer    = i_in_valid && a_ready;

    assign o_cfg_ready = 1'b1;

    // endpoint ordering for a start
    always_comb begin
        dx     = (i_end_x >= i_start_x) ? i_end_x - i_start_x : i_start_x - i_end_x;
        dy     = (i_end_y >= i_start_y) ? i_end_y - i_start_y : i_start_y - i_end_y;
        ymaj_s = dy > dx;
        dmaj   = ymaj_s ? dy : dx;
        dmin   = ymaj_s ? dx : dy;
        ma0    = ymaj_s ? i_start_y : i_start_x;
        mi0    = ymaj_s ? i_start_x : i_start_y;
        ma1    = ymaj_s ? i_end_y   : i_end_x;
        mi1    = ymaj_s ? i_end_x   : i_end_y;
        swap   = ma1 < ma0;
        if (swap) begin
            {ma0, ma1} = {ma1, ma0};
            {mi0, mi1} = {mi1, mi0};
        end
        two_dmin = $signed({2'b00, dmin, 1'b0});
        two_dmaj = $signed({2'b00, dmaj, 1'b0});
        one_dmaj = $signed({3'b000, dmaj});
    end

    assign step_major = r_cur_major + COORD_BITS'(1);

    // next line state
    always_comb begin
        n_cur_major  = r_cur_major;
        n_cur_minor  = r_cur_minor;
        n_major_end  = r_major_end;
        n_decision   = r_decision;
        n_straight   = r_straight;
        n_diagonal   = r_diagonal;
        n_minor_down = r_minor_down;
        n_y_major    = r_y_major;
        n_busy       = r_busy;
        n_color      = r_color;
        emit         = 1'b0;
        if (in_xfer) begin
            if (i_func == FUNC_START) begin
                n_y_major    = ymaj_s;
                n_minor_down = mi1 < mi0;
                n_decision   = two_dmin - one_dmaj;
                n_straight   = two_dmin;
                n_diagonal   = two_dmin - two_dmaj;
                n_cur_major  = ma0;
                n_cur_minor  = mi0;
                n_major_end  = ma1;
                n_color      = i_draw_color;
                emit         = 1'b1;
            end else if (r_busy) begin
                n_cur_major = step_major;
                if (r_decision < 0) begin
                    n_decision = r_decision + r_straight;
                end else begin
                    n_decision  = r_decision + r_diagonal;
                    n_cur_minor = r_minor_down ? r_cur_minor - COORD_BITS'(1)
                                               : r_cur_minor + COORD_BITS'(1);
                end
                emit = 1'b1;
            end
            if (emit) begin
                n_busy = (n_cur_major != n_major_end);
            end
        end
    end

    // configuration and line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch      <= PITCH_RESET;
            r_base       <= '0;
            r_cur_major  <= '0;
            r_cur_minor  <= '0;
            r_major_end  <= '0;
            r_decision   <= '0;
            r_straight   <= '0;
            r_diagonal   <= '0;
            r_minor_down <= 1'b0;
            r_y_major    <= 1'b0;
            r_busy       <= 1'b0;
            r_color      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_LINE_PITCH:   r_pitch <= i_cfg_data[PITCH_W-1:0];
                    REG_SURFACE_BASE: r_base  <= i_cfg_data[BASE_W-1:0];
                endcase
            end
            r_cur_major  <= n_cur_major;
            r_cur_minor  <= n_cur_minor;
            r_major_end  <= n_major_end;
            r_decision   <= n_decision;
            r_straight   <= n_straight;
            r_diagonal   <= n_diagonal;
            r_minor_down <= n_minor_down;
            r_y_major    <= n_y_major;
            r_busy       <= n_busy;
            r_color      <= n_color;
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= emit;
            if (b_ready) r_b_valid <= r_a_valid;
            if (c_ready) r_c_valid <= r_b_valid;
        end
    end

    // base + row offset + x, wrapping at the address width
    assign addr_sum = EXT_W'(r_base) + EXT_W'(r_b_prod) + EXT_W'(r_b_px);

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (a_ready && emit) begin
            r_a_px    <= n_y_major ? n_cur_minor : n_cur_major;
            r_a_py    <= n_y_major ? n_cur_major : n_cur_minor;
            r_a_color <= n_color;
            r_a_last  <= !n_busy;
        end
        if (b_ready && r_a_valid) begin
            r_b_px    <= r_a_px;
            r_b_py    <= r_a_py;
            r_b_color <= r_a_color;
            r_b_last  <= r_a_last;
            r_b_prod  <= PROD_W'(r_a_py) * PROD_W'(r_pitch);
        end
        if (c_ready && r_b_valid) begin
            r_c_px    <= r_b_px;
            r_c_py    <= r_b_py;
            r_c_color <= r_b_color;
            r_c_last  <= r_b_last;
            r_c_addr  <= addr_sum[ADDRESS_BITS-1:0];
        end
    end

    assign o_out_valid     = r_c_valid;
    assign o_pixel_x       = r_c_px;
    assign o_pixel_y       = r_c_py;
    assign o_pixel_color   = r_c_color;
    assign o_pixel_address = r_c_addr;
    assign o_last_pixel    = r_c_last;

endmodule

// ===== rtl/mlr_checker.sv =====
// ----------------------------------------------------------------------------
// mlr_checker
// port level checks on the line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
module mlr_checker #(
    parameter int COORD_BITS   = mlr_pkg::COORD_BITS_DEF,
    parameter int ADDRESS_BITS = mlr_pkg::ADDRESS_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_func,
    input logic [COORD_BITS-1:0]         i_start_x,
    input logic [COORD_BITS-1:0]         i_start_y,
    input logic [COORD_BITS-1:0]         i_end_x,
    input logic [COORD_BITS-1:0]         i_end_y,
    input logic [mlr_pkg::COLOR_W-1:0]   i_draw_color,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [COORD_BITS-1:0]         o_pixel_x,
    input logic [COORD_BITS-1:0]         o_pixel_y,
    input logic [mlr_pkg::COLOR_W-1:0]   o_pixel_color,
    input logic [ADDRESS_BITS-1:0]       o_pixel_address,
    input logic                          o_last_pixel
);
    import mlr_pkg::*;

    logic in_xfer, start_xfer, point_xfer;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign start_xfer = in_xfer && (i_func == FUNC_START);
    assign point_xfer = start_xfer && (i_start_x == i_end_x) && (i_start_y == i_end_y);

    // no pixel straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("pixel valid right after reset");

    // a stalled pixel holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_address)
            && $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_last_pixel))
        else $error("stalled pixel changed");

    // a start always yields its first pixel when the output does not stall while it crosses stages a and b
    a_start_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_xfer ##1 !i_out_stall ##1 !i_out_stall |=> o_out_valid)
        else $error("start gave no pixel");

    // a single-point line is one pixel, marked last, at its own coordinates
    a_point_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        point_xfer ##1 !i_out_stall ##1 !i_out_stall |=>
            o_out_valid && o_last_pixel && (o_pixel_x == $past(i_start_x, 3))
            && (o_pixel_y == $past(i_start_y, 3))
            && (o_pixel_color == $past(i_draw_color, 3)))
        else $error("single-point line pixel wrong");

endmodule

bind midpoint_line_rasterizer mlr_checker #(
    .COORD_BITS  (COORD_BITS),
    .ADDRESS_BITS(ADDRESS_BITS)
) u_mlr_checker (.*);

// ===== bench/mlr_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlr_tb_pkg
// pixel prediction and checking for the line rasterizer bench
// ----------------------------------------------------------------------------
package mlr_tb_pkg;

    import mlr_pkg::*;

    typedef logic [COORD_BITS_DEF-1:0]   t_coord;
    typedef logic [COLOR_W-1:0]          t_color;
    typedef logic [ADDRESS_BITS_DEF-1:0] t_addr;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_color color;
        t_addr  address;
        logic   last;
    } t_pixel;

    class raster_ledger;

        // surface registers
        logic [PITCH_W-1:0] pitch = PITCH_RESET;
        logic [BASE_W-1:0]  base  = '0;

        // line walker state
        t_coord             cur_major  = '0;
        t_coord             cur_minor  = '0;
        t_coord             major_end  = '0;
        logic signed [14:0] decision   = '0;
        logic signed [14:0] straight   = '0;
        logic signed [14:0] diagonal   = '0;
        logic               minor_down = 1'b0;
        logic               y_major    = 1'b0;
        logic               busy       = 1'b0;
        t_color             held_color = '0;

        t_pixel      pending_pixels[$];
        int unsigned pixels_predicted = 0;
        int unsigned mismatches       = 0;

        function void set_register(t_cfg_reg idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_LINE_PITCH:   pitch = data[PITCH_W-1:0];
                REG_SURFACE_BASE: base  = data[BASE_W-1:0];
                default: ;
            endcase
        endfunction

        function t_pixel next_pixel();
            t_pixel p;
            p.x       = y_major ? cur_minor : cur_major;
            p.y       = y_major ? cur_major : cur_minor;
            p.color   = held_color;
            p.address = base + p.y * pitch + p.x;
            p.last    = (cur_major == major_end);
            busy      = !p.last;
            return p;
        endfunction

        function void accept_item(logic func, t_coord sx, t_coord sy, t_coord ex,
                                  t_coord ey, t_color color);
            int     x1, y1, x2, y2, dx, dy, dmaj, dmin;
            t_coord ma0, mi0, ma1, mi1, swap;
            x1 = sx;
            y1 = sy;
            x2 = ex;
            y2 = ey;
            if (func == FUNC_START) begin
                dx      = (x2 >= x1) ? x2 - x1 : x1 - x2;
                dy      = (y2 >= y1) ? y2 - y1 : y1 - y2;
                y_major = dy > dx;
                if (y_major) begin
                    ma0 = sy; mi0 = sx; ma1 = ey; mi1 = ex; dmaj = dy; dmin = dx;
                end else begin
                    ma0 = sx; mi0 = sy; ma1 = ex; mi1 = ey; dmaj = dx; dmin = dy;
                end
                // walk with the major coordinate increasing
                if (ma1 < ma0) begin
                    swap = ma0; ma0 = ma1; ma1 = swap;
                    swap = mi0; mi0 = mi1; mi1 = swap;
                end
                minor_down = mi1 < mi0;
                decision   = 15'(2 * dmin - dmaj);
                straight   = 15'(2 * dmin);
                diagonal   = 15'(2 * (dmin - dmaj));
                cur_major  = ma0;
                cur_minor  = mi0;
                major_end  = ma1;
                held_color = color;
            end else if (!busy) begin
                return;
            end else begin
                cur_major = cur_major + 1'b1;
                if (decision < 0) begin
                    decision = decision + straight;
                end else begin
                    decision  = decision + diagonal;
                    cur_minor = minor_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
                end
            end
            pending_pixels.push_back(next_pixel());
            pixels_predicted++;
        endfunction

        function void match_pixel(t_pixel got);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                $error("pixel with none expected: x %0d y %0d", got.x, got.y);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.x !== want.x) begin
                $error("pixel_x: expected %0d, actual %0d", want.x, got.x);
                mismatches++;
            end
            if (got.y !== want.y) begin
                $error("pixel_y: expected %0d, actual %0d", want.y, got.y);
                mismatches++;
            end
            if (got.color !== want.color) begin
                $error("pixel_color: expected %0d, actual %0d", want.color, got.color);
                mismatches++;
            end
            if (got.address !== want.address) begin
                $error("pixel_address: expected %h, actual %h", want.address, got.address);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last_pixel: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// ===== bench/tb_midpoint_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midpoint_line_rasterizer
// self-checking bench for the midpoint line rasterizer: directed lines over
// several octants and corner cases, then random line sequences under four surface
// settings, with random gaps on the item side and random output stalls
// ----------------------------------------------------------------------------
module tb_midpoint_line_rasterizer;

    import mlr_pkg::*;
    import mlr_tb_pkg::*;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // item channel
    logic   in_valid = 1'b0;
    logic   in_stall;
    logic   in_func  = FUNC_START;
    t_coord in_sx    = '0;
    t_coord in_sy    = '0;
    t_coord in_ex    = '0;
    t_coord in_ey    = '0;
    t_color in_color = '0;

    // pixel channel
    logic   out_valid;
    logic   out_stall = 1'b0;
    t_coord pix_x;
    t_coord pix_y;
    t_color pix_color;
    t_addr  pix_address;
    logic   pix_last;

    // register write channel
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    t_cfg_reg             cfg_index = REG_LINE_PITCH;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    raster_ledger ledger = new;

    // when set, neither side idles: back-to-back transfers
    logic steady = 1'b0;
    // output stall cycles still to serve after the last pixel transfer
    int   stall_left = 0;
    // pixel transfers seen at the rising edge, and those already given a stall
    int   pixels_taken  = 0;
    int   pixels_served = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    midpoint_line_rasterizer i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_func          (in_func),
        .i_start_x       (in_sx),
        .i_start_y       (in_sy),
        .i_end_x         (in_ex),
        .i_end_y         (in_ey),
        .i_draw_color    (in_color),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_pixel_x       (pix_x),
        .o_pixel_y       (pix_y),
        .o_pixel_color   (pix_color),
        .o_pixel_address (pix_address),
        .o_last_pixel    (pix_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // pixel transfers are checked at the rising edge, before the block updates
    always @(posedge clk) begin
        t_pixel seen;
        if (rst_n && out_valid && !out_stall) begin
            seen.x       = pix_x;
            seen.y       = pix_y;
            seen.color   = pix_color;
            seen.address = pix_address;
            seen.last    = pix_last;
            ledger.match_pixel(seen);
            pixels_taken++;
        end
    end

    // receiver stall, driven at the falling edge
    always @(negedge clk) begin
        // stall drawn per pixel, zero during steady stretches
        if (pixels_taken != pixels_served) begin
            pixels_served = pixels_taken;
            stall_left    = steady ? 0 : $urandom_range(0, 5);
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // one item transfer; entered and left at a falling edge, valid left high so
    // that the next item can follow with no gap
    task automatic send_item(logic func, t_coord sx, t_coord sy, t_coord ex,
                             t_coord ey, t_color color);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= func;
        in_sx    <= sx;
        in_sy    <= sy;
        in_ex    <= ex;
        in_ey    <= ey;
        in_color <= color;
        do @(posedge clk); while (in_stall);
        ledger.accept_item(func, sx, sy, ex, ey, color);
        @(negedge clk);
    endtask

    // step items carry random payload, which the block must ignore
    task automatic send_step();
        send_item(FUNC_STEP, t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                  t_coord'($urandom), t_color'($urandom));
    endtask

    task automatic draw_line(t_coord sx, t_coord sy, t_coord ex, t_coord ey,
                             t_color color, int steps);
        send_item(FUNC_START, sx, sy, ex, ey, color);
        repeat (steps) send_step();
    endtask

    // sender holds off until every pixel is out, then lets the pipe run dry
    // (an idle step leaves no pixel to wait for)
    task automatic settle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (ledger.pending_pixels.size() != 0 && guard < 5000) begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
    endtask

    // both surface registers, back to back; only while the block is idle
    task automatic write_regs(logic [PITCH_W-1:0] pitch, logic [BASE_W-1:0] base);
        cfg_valid <= 1'b1;
        cfg_index <= REG_LINE_PITCH;
        cfg_data  <= CFG_DAT_W'(pitch);
        do @(posedge clk); while (!cfg_ready);
        ledger.set_register(REG_LINE_PITCH, CFG_DAT_W'(pitch));
        @(negedge clk);
        cfg_index <= REG_SURFACE_BASE;
        cfg_data  <= CFG_DAT_W'(base);
        do @(posedge clk); while (!cfg_ready);
        ledger.set_register(REG_SURFACE_BASE, CFG_DAT_W'(base));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    // one random sequence: mostly complete short lines anywhere on the surface,
    // some abandoned lines with far endpoints, and stray steps
    task automatic random_sequence();
        int kind, span, minor_len, x_off, y_off, sx, sy, ex, ey, dx, dy, steps;
        kind   = $urandom_range(0, 99);
        steady = ($urandom_range(0, 7) == 0);
        sx     = $urandom_range(0, 4095);
        sy     = $urandom_range(0, 4095);
        if (kind < 72) begin
            // short lines mostly, a few longer ones
            span      = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 120)
                                                     : $urandom_range(0, 16);
            minor_len = $urandom_range(0, span);
            if ($urandom_range(0, 1)) begin
                x_off = span;
                y_off = minor_len;
            end else begin
                x_off = minor_len;
                y_off = span;
            end
            ex    = clamp_coord($urandom_range(0, 1) ? sx + x_off : sx - x_off);
            ey    = clamp_coord($urandom_range(0, 1) ? sy + y_off : sy - y_off);
            dx    = (ex > sx) ? ex - sx : sx - ex;
            dy    = (ey > sy) ? ey - sy : sy - ey;
            // walk to the end, now and then a step or two past it
            steps = ((dx > dy) ? dx : dy)
                  + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            draw_line(t_coord'(sx), t_coord'(sy), t_coord'(ex), t_coord'(ey),
                      t_color'($urandom), steps);
        end else if (kind < 90) begin
            // far endpoints, left unfinished for the next start to abandon
            draw_line(t_coord'(sx), t_coord'(sy), t_coord'($urandom), t_coord'($urandom),
                      t_color'($urandom), $urandom_range(0, 8));
        end else begin
            repeat ($urandom_range(1, 2)) send_step();
        end
    endtask

    task automatic random_phase(int unsigned pixels);
        int unsigned target;
        target = ledger.pixels_predicted + pixels;
        while (ledger.pixels_predicted < target)
            random_sequence();
        steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed lines at the reset surface settings
        // single point: first pixel is also the last
        draw_line(12'd5, 12'd5, 12'd5, 12'd5, 8'h00, 0);
        // step with no active line, all-ones payload
        send_item(FUNC_STEP, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF);
        // horizontal: equal minor coordinates never step diagonally
        draw_line(12'd0, 12'd0, 12'd3, 12'd0, 8'hFF, 3);
        // vertical, endpoints given with y decreasing so they get swapped
        draw_line(12'd4095, 12'd4095, 12'd4095, 12'd4092, 8'h5A, 3);
        // x-major with the minor axis stepping down
        draw_line(12'd0, 12'd4095, 12'd3, 12'd4093, 8'hA5, 3);
        // full-surface diagonals, each abandoned by the next start
        draw_line(12'd4095, 12'd0, 12'd0, 12'd4095, 8'h0F, 2);
        draw_line(12'd0, 12'd0, 12'd4095, 12'd4095, 8'hF0, 1);
        // y-major, minor up
        draw_line(12'd20, 12'd30, 12'd21, 12'd34, 8'h33, 4);
        settle();

        // random lines under several surface settings, extremes first
        write_regs(16'd1, 32'hFFFF_FFFF);
        random_phase(200);
        settle();
        write_regs(16'hFFFF, 32'hFFF0_0000);
        random_phase(200);
        settle();
        write_regs(PITCH_W'($urandom_range(1, 65535)), $urandom);
        random_phase(200);
        settle();
        write_regs(PITCH_RESET, 32'h0000_0000);
        random_phase(200);
        settle();

        if (ledger.pending_pixels.size() != 0) begin
            $error("%0d expected pixels never came out", ledger.pending_pixels.size());
            ledger.mismatches++;
        end
        if (ledger.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #500000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
